FILE: rtl/core/psfr_pkg.sv
// ----------------------------------------------------------------------------
// psfr_pkg
// Shared constants and types of the particle sensor frame receiver.
// ----------------------------------------------------------------------------
package psfr_pkg;

    // Frame layout
    localparam int FRAME_BYTES = 28;
    localparam int STORE_DEPTH = 12;
    localparam int RAW_WORDS   = (FRAME_BYTES - 4) / 2;
    localparam int MEAS_WORDS  = (RAW_WORDS > STORE_DEPTH) ? STORE_DEPTH : RAW_WORDS;

    localparam int BYTE_CNT_W  = 6;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int TICK_W      = 20;

    localparam logic [7:0] START_HI = 8'h42;
    localparam logic [7:0] START_LO = 8'h4D;

    localparam logic [15:0]           FRAME_LEN_WORD = 16'(FRAME_BYTES);
    localparam logic [BYTE_CNT_W-1:0] CKSUM_HI_POS   = BYTE_CNT_W'(FRAME_BYTES - 2);
    localparam logic [ADDR_W-1:0]     LAST_ADDR      = ADDR_W'(MEAS_WORDS - 1);

    // Input operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register indexes
    localparam logic REG_ENABLE  = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOINIT  = 3'd1,
        ST_BADLEN  = 3'd2,
        ST_CKSUM   = 3'd3,
        ST_TIMEOUT = 3'd4
    } t_status;

    // Parser phase, one-hot
    typedef enum logic [4:0] {
        PH_HUNT1 = 5'b00001,
        PH_HUNT2 = 5'b00010,
        PH_LENHI = 5'b00100,
        PH_LENLO = 5'b01000,
        PH_DATA  = 5'b10000
    } t_phase;

    // Control from the parser to the hunt timer
    typedef struct packed {
        logic tick;
        logic clear;
    } t_timer_ctl;

endpackage

FILE: rtl/core/psfr_hunt_timer.sv
// ----------------------------------------------------------------------------
// psfr_hunt_timer
// Counts timer ticks while the parser hunts and flags the timeout.
// ----------------------------------------------------------------------------
module psfr_hunt_timer
    import psfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_timer_ctl        i_ctl,
    input  logic [TICK_W-1:0] i_limit,
    output logic              o_timeout
);

    logic [TICK_W-1:0] r_count;
    logic [TICK_W-1:0] n_count;
    logic [TICK_W-1:0] inc;
    logic [TICK_W-1:0] limit;

    // A limit of zero behaves as one
    assign limit = (i_limit == '0) ? TICK_W'(1) : i_limit;
    assign inc   = r_count + TICK_W'(1);

    // High when the next tick reaches the limit; the parser qualifies it
    assign o_timeout = (inc >= limit);

    always_comb begin
        n_count = r_count;
        if (i_ctl.clear) begin
            n_count = '0;
        end else if (i_ctl.tick) begin
            n_count = (inc >= limit) ? '0 : inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

FILE: rtl/core/particle_sensor_frame_receiver.sv
// ----------------------------------------------------------------------------
// particle_sensor_frame_receiver
// Serial frame parser for a particle sensor: hunt, length check, checksum,
// and a burst of twelve measurement words from the word store.
// ----------------------------------------------------------------------------
// Each received byte or timer tick is taken while no burst runs, provided the
// output register is free or being emptied in that cycle. A status result
// appears in the output register the cycle after its transfer. A good frame is
// reported as a burst of twelve words read from the word store, a memory with
// one write port and a registered read port: each word is read by its address,
// then its registered data, then loaded into the output register, and no input
// is taken until the last word has been loaded. Configuration is written
// through a plain write port and should change only while idle.
// ----------------------------------------------------------------------------
module particle_sensor_frame_receiver
    import psfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [TICK_W-1:0] i_cfg_data,
    // Input channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_operation,
    input  logic [7:0]        i_rx_byte,
    // Result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_status,
    output logic [3:0]        o_word_index,
    output logic [15:0]       o_word_value,
    output logic              o_last
);

    // Configuration registers
    logic              r_enable;
    logic [TICK_W-1:0] r_timeout;

    // Parser state
    t_phase                r_phase,  n_phase;
    logic [BYTE_CNT_W-1:0] r_cnt,    n_cnt;
    logic [7:0]            r_held,   n_held;
    logic [15:0]           r_sum,    n_sum;
    logic [7:0]            r_ckhi,   n_ckhi;

    // Word store and burst read
    logic [15:0]       mem [STORE_DEPTH];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic [15:0]       r_rd_data;
    logic [ADDR_W-1:0] r_rd_addr;
    logic              r_rd_ok;
    logic              r_burst;

    // Output register
    logic              r_out_valid;
    t_status           r_status;
    logic [3:0]        r_index;
    logic [15:0]       r_value;
    logic              r_last;

    logic              in_xfer;
    logic              out_free;
    logic              hunting;
    logic              to_hunt;
    logic              res_valid;
    t_status           res_status;
    logic              start_burst;
    logic              load_word;
    logic [BYTE_CNT_W-2:0] word_num;
    t_timer_ctl        tmr_ctl;
    logic              timeout;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_burst && out_free;
    assign in_xfer    = i_in_valid && o_in_ready;

    // Any phase outside the frame body counts as hunting
    assign hunting  = !((r_phase == PH_LENHI) || (r_phase == PH_LENLO) ||
                        (r_phase == PH_DATA));
    assign word_num = r_cnt[BYTE_CNT_W-1:1];

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_timeout <= TICK_W'(5000);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ENABLE:  r_enable  <= i_cfg_data[0];
                REG_TIMEOUT: r_timeout <= i_cfg_data;
                default:     r_enable  <= r_enable;
            endcase
        end
    end

    psfr_hunt_timer u_timer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (tmr_ctl),
        .i_limit   (r_timeout),
        .o_timeout (timeout)
    );

    // Parser next state
    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_held      = r_held;
        n_sum       = r_sum;
        n_ckhi      = r_ckhi;
        to_hunt     = 1'b0;
        res_valid   = 1'b0;
        res_status  = ST_OK;
        start_burst = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = word_num[ADDR_W-1:0];
        mem_wdata   = {r_held, i_rx_byte};
        tmr_ctl     = '0;
        if (in_xfer) begin
            if (i_operation == OP_TICK) begin
                if (hunting && (r_phase != PH_HUNT2)) begin
                    n_phase = PH_HUNT1;
                end
                if (r_enable && hunting) begin
                    tmr_ctl.tick = 1'b1;
                    if (timeout) begin
                        res_valid  = 1'b1;
                        res_status = ST_TIMEOUT;
                    end
                end
            end else if (!r_enable) begin
                to_hunt    = 1'b1;
                res_valid  = 1'b1;
                res_status = ST_NOINIT;
            end else begin
                case (r_phase)
                    PH_HUNT2: begin
                        if (i_rx_byte == START_LO) begin
                            n_phase = PH_LENHI;
                            n_sum   = 16'(START_HI) + 16'(START_LO);
                        end else if (i_rx_byte != START_HI) begin
                            n_phase = PH_HUNT1;
                        end
                    end
                    PH_LENHI: begin
                        n_held  = i_rx_byte;
                        n_sum   = r_sum + {8'h00, i_rx_byte};
                        n_phase = PH_LENLO;
                    end
                    PH_LENLO: begin
                        if ({r_held, i_rx_byte} != FRAME_LEN_WORD) begin
                            to_hunt    = 1'b1;
                            res_valid  = 1'b1;
                            res_status = ST_BADLEN;
                        end else begin
                            n_sum   = r_sum + {8'h00, i_rx_byte};
                            n_cnt   = '0;
                            n_phase = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        if (r_cnt < CKSUM_HI_POS) begin
                            n_sum = r_sum + {8'h00, i_rx_byte};
                            n_cnt = r_cnt + BYTE_CNT_W'(1);
                            if (!r_cnt[0]) begin
                                n_held = i_rx_byte;
                            end else if (word_num < (BYTE_CNT_W-1)'(MEAS_WORDS)) begin
                                mem_we = 1'b1;
                            end
                        end else if (r_cnt == CKSUM_HI_POS) begin
                            n_ckhi = i_rx_byte;
                            n_cnt  = r_cnt + BYTE_CNT_W'(1);
                        end else if ({r_ckhi, i_rx_byte} != r_sum) begin
                            to_hunt    = 1'b1;
                            res_valid  = 1'b1;
                            res_status = ST_CKSUM;
                        end else begin
                            to_hunt     = 1'b1;
                            start_burst = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = (i_rx_byte == START_HI) ? PH_HUNT2 : PH_HUNT1;
                    end
                endcase
            end
            if (to_hunt) begin
                n_phase       = PH_HUNT1;
                n_cnt         = '0;
                n_held        = '0;
                n_sum         = '0;
                n_ckhi        = '0;
                tmr_ctl.clear = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
            r_cnt   <= '0;
            r_held  <= '0;
            r_sum   <= '0;
            r_ckhi  <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_held  <= n_held;
            r_sum   <= n_sum;
            r_ckhi  <= n_ckhi;
        end
    end

    // Word store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[r_rd_addr];
    end

    // Burst sequencing: address, then registered data, then load
    assign load_word = r_burst && r_rd_ok && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst   <= 1'b0;
            r_rd_ok   <= 1'b0;
            r_rd_addr <= '0;
        end else if (start_burst) begin
            r_burst   <= 1'b1;
            r_rd_ok   <= 1'b0;
            r_rd_addr <= '0;
        end else if (r_burst) begin
            if (load_word) begin
                if (r_rd_addr == LAST_ADDR) begin
                    r_burst <= 1'b0;
                end else begin
                    r_rd_addr <= r_rd_addr + ADDR_W'(1);
                end
                r_rd_ok <= 1'b0;
            end else begin
                r_rd_ok <= 1'b1;
            end
        end
    end

    // Output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid || load_word) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_status <= res_status;
            r_index  <= '0;
            r_value  <= '0;
            r_last   <= 1'b1;
        end else if (load_word) begin
            r_status <= ST_OK;
            r_index  <= 4'(r_rd_addr);
            r_value  <= r_rd_data;
            r_last   <= (r_rd_addr == LAST_ADDR);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_word_index = r_index;
    assign o_word_value = r_value;
    assign o_last       = r_last;

    // Checks
    a_no_input_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_burst |-> !o_in_ready)
        else $error("input taken during result burst");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |->
            (o_last && (o_word_index == 4'd0) && (o_word_value == 16'd0)))
        else $error("status result with payload or without last");

    a_burst_ends_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_burst) |-> (o_out_valid && o_last && (o_status == ST_OK)))
        else $error("burst ended without its last word");

    a_burst_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_burst |=> (r_burst && !r_rd_ok && (r_rd_addr == '0)))
        else $error("burst did not start from the first word");

endmodule
